[design/gmpc_pkg.sv]
// gmpc_pkg: shared types and constants for the grid max path count block
// used by every module of the block; depends on nothing else
`timescale 1ns / 1ps

package gmpc_pkg;

   // field widths
   localparam int KIND_W  = 2;
   localparam int DIGIT_W = 4;
   localparam int BOARD_W = 8;
   localparam int SCORE_W = 13;
   localparam int BEST_W  = 12;
   localparam int COUNT_W = 30;
   localparam int SUM_W   = 32;

   // port widths
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = 1;

   // cell kinds
   localparam logic [KIND_W-1:0] KIND_DIGIT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OBSTACLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_END      = 2'd3;

   localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

   // score pattern for a cell no path reaches
   localparam logic [SCORE_W-1:0] NO_PATH = 13'h1FFF;

   // count modulus and its double, for the reduction after the three-way add
   localparam logic [SUM_W-1:0] PATH_MOD  = 32'd1000000007;
   localparam logic [SUM_W-1:0] PATH_MOD2 = 32'd2000000014;

   // score and count of one board cell
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [COUNT_W-1:0] count;
   } pair_type;

   localparam pair_type NO_PAIR = '{score: NO_PATH, count: '0};

   // per-stage control of the row chain
   typedef struct packed {
      logic shift;
      logic take_new;
   } cell_ctl_type;

endpackage

[design/gmpc_cell.sv]
// gmpc_cell: one stage of the row chain, holding the score and count of one column
// depends on gmpc_pkg
`timescale 1ns / 1ps

module gmpc_cell (
   input  logic                  clock,
   input  gmpc_pkg::cell_ctl_type ctl,
   input  gmpc_pkg::pair_type    prev_pair,
   input  gmpc_pkg::pair_type    new_pair,
   output gmpc_pkg::pair_type    pair_out
);
   import gmpc_pkg::*;

   pair_type pair_ff;
   pair_type pair_in;

   // on a shift the insert stage takes the fresh result, every other stage takes its neighbor; all hold otherwise
   always_comb begin
      pair_in = pair_ff;
      if (ctl.shift) begin
         pair_in = ctl.take_new ? new_pair : prev_pair;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   assign pair_out = pair_ff;

endmodule

[design/gmpc_eval.sv]
// gmpc_eval: score and path count of one cell from its three neighbors
// depends on gmpc_pkg
`timescale 1ns / 1ps

module gmpc_eval (
   input  logic [gmpc_pkg::KIND_W-1:0]  cell_kind,
   input  logic [gmpc_pkg::DIGIT_W-1:0] cell_digit,
   input  gmpc_pkg::pair_type           below,
   input  gmpc_pkg::pair_type           right,
   input  gmpc_pkg::pair_type           diag,
   output gmpc_pkg::pair_type           result
);
   import gmpc_pkg::*;

   logic [SCORE_W-1:0] best;
   logic [DIGIT_W-1:0] add_val;
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]   reduced;
   logic [BEST_W-1:0]  new_score;

   // best reachable neighbor score
   always_comb begin
      best = NO_PATH;
      if (below.score != NO_PATH) begin
         best = below.score;
      end
      if (right.score != NO_PATH && (best == NO_PATH || right.score > best)) begin
         best = right.score;
      end
      if (diag.score != NO_PATH && (best == NO_PATH || diag.score > best)) begin
         best = diag.score;
      end
   end

   // saturated digit, end cells add nothing
   always_comb begin
      add_val = '0;
      if (cell_kind == KIND_DIGIT) begin
         add_val = (cell_digit > MAX_DIGIT) ? MAX_DIGIT : cell_digit;
      end
   end

   assign new_score = best[BEST_W-1:0] + BEST_W'(add_val);

   // sum the counts of all neighbors that tie for best, then reduce below the modulus
   always_comb begin
      sum = '0;
      if (below.score == best) begin
         sum = sum + SUM_W'(below.count);
      end
      if (right.score == best) begin
         sum = sum + SUM_W'(right.count);
      end
      if (diag.score == best) begin
         sum = sum + SUM_W'(diag.count);
      end
      if (sum >= PATH_MOD2) begin
         reduced = sum - PATH_MOD2;
      end else if (sum >= PATH_MOD) begin
         reduced = sum - PATH_MOD;
      end else begin
         reduced = sum;
      end
   end

   // cell result by kind
   always_comb begin
      case (cell_kind)
         KIND_START: begin
            result = '{score: '0, count: COUNT_W'(1)};
         end
         KIND_OBSTACLE: begin
            result = NO_PAIR;
         end
         KIND_DIGIT, KIND_END: begin
            if (best != NO_PATH) begin
               result = '{score: {1'b0, new_score}, count: reduced[COUNT_W-1:0]};
            end else begin
               result = NO_PAIR;
            end
         end
         default: begin
            result = NO_PAIR;
         end
      endcase
   end

endmodule

[design/grid_max_path_count.sv]
// Best path score and number of best paths on a square board. Cells arrive in reverse
// raster order, bottom-right first, one item per cycle; the block takes a cell in every
// cycle, and the input stalls only while a finished result waits on the rsp side. The
// result is registered and appears in the cycle after the top-left cell is taken. The rate is set by the loop
// from one cell's count to its left neighbor: three-way add and modular reduction done
// combinationally. The row below is held in a chain of MAX_SIDE stages that shift once per
// item; a new entry enters at the stage that makes it leave the chain one row later.
// depends on gmpc_pkg, gmpc_cell, gmpc_eval
`timescale 1ns / 1ps

module grid_max_path_count #(
   parameter int MAX_SIDE = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // cell_kind [1:0]
   input  logic [gmpc_pkg::REQ_TUSER_W-1:0]     req_tuser,
   // cell_digit [3:0], zero padded
   input  logic [gmpc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // best_score [11:0], path_count [41:12], zero padded
   output logic [gmpc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // reachable [0]
   output logic [gmpc_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // board_size [7:0]
   input  logic [gmpc_pkg::BOARD_W-1:0]         csr_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready
);
   import gmpc_pkg::*;

   localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

   // side length minus one, with zero acting as one and large values clamped
   function automatic logic [IDX_W-1:0] side_m1_of(input logic [BOARD_W-1:0] bs);
      logic [IDX_W-1:0] r;
      if (bs == '0) begin
         r = '0;
      end else if (32'(bs) > 32'(MAX_SIDE)) begin
         r = IDX_W'(MAX_SIDE - 1);
      end else begin
         r = IDX_W'(32'(bs) - 32'd1);
      end
      return r;
   endfunction

   logic [BOARD_W-1:0] board_size_ff, board_size_in;
   logic [IDX_W-1:0]   col_ff, col_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   pair_type           right_ff, right_in;
   pair_type           diag_ff, diag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;

   logic               accept;
   logic               csr_write;
   logic               last_cell;
   logic [IDX_W-1:0]   side_m1;
   logic [IDX_W-1:0]   ins_pos;
   pair_type           below, right_eff, diag_eff, new_pair;
   pair_type           chain [MAX_SIDE];

   assign side_m1    = side_m1_of(board_size_ff);
   assign ins_pos    = IDX_W'(MAX_SIDE - 1) - side_m1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign last_cell  = (col_ff == '0) && (row_ff == '0);

   // board edges read as unreachable
   assign below     = (row_ff == side_m1) ? NO_PAIR : chain[MAX_SIDE-1];
   assign right_eff = (col_ff == side_m1) ? NO_PAIR : right_ff;
   assign diag_eff  = (col_ff == side_m1) ? NO_PAIR : diag_ff;

   gmpc_eval u_eval (
      .cell_kind  (req_tuser[KIND_W-1:0]),
      .cell_digit (req_tdata[DIGIT_W-1:0]),
      .below      (below),
      .right      (right_eff),
      .diag       (diag_eff),
      .result     (new_pair)
   );

   // row chain, stage zero has no upstream neighbor
   for (genvar k = 0; k < MAX_SIDE; k++) begin : g_row
      cell_ctl_type ctl;
      assign ctl.shift    = accept;
      assign ctl.take_new = (ins_pos == IDX_W'(k));
      if (k == 0) begin : g_head
         gmpc_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .prev_pair (new_pair),
            .new_pair  (new_pair),
            .pair_out  (chain[k])
         );
      end else begin : g_body
         gmpc_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .prev_pair (chain[k-1]),
            .new_pair  (new_pair),
            .pair_out  (chain[k])
         );
      end
   end

   // position counters, neighbor registers and board size
   always_comb begin
      board_size_in = board_size_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      right_in      = right_ff;
      diag_in       = diag_ff;
      if (csr_write) begin
         board_size_in = csr_data;
         col_in        = side_m1_of(csr_data);
         row_in        = side_m1_of(csr_data);
         right_in      = NO_PAIR;
         diag_in       = NO_PAIR;
      end else if (accept) begin
         diag_in  = below;
         right_in = new_pair;
         if (last_cell) begin
            col_in   = side_m1;
            row_in   = side_m1;
            right_in = NO_PAIR;
            diag_in  = NO_PAIR;
         end else if (col_ff == '0) begin
            col_in = side_m1;
            row_in = row_ff - IDX_W'(1);
         end else begin
            col_in = col_ff - IDX_W'(1);
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (accept && last_cell) begin
         rsp_valid_in = 1'b1;
         if (new_pair.score == NO_PATH) begin
            rsp_data_in = '0;
            rsp_user_in = '0;
         end else begin
            rsp_data_in = RSP_TDATA_W'({new_pair.count, new_pair.score[BEST_W-1:0]});
            rsp_user_in = RSP_TUSER_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_size_ff <= BOARD_W'(1);
         col_ff        <= '0;
         row_ff        <= '0;
         right_ff      <= NO_PAIR;
         diag_ff       <= NO_PAIR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         board_size_ff <= board_size_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         right_ff      <= right_in;
         diag_ff       <= diag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[design/gmpc_checker.sv]
// gmpc_checker: port-level checks of grid_max_path_count, bound to the top level
// depends on gmpc_pkg and grid_max_path_count
`timescale 1ns / 1ps

module gmpc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [gmpc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [gmpc_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);
   import gmpc_pkg::*;

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // input stalls only behind a waiting result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

   // an unreachable board reports all zeros
   a_no_path_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("no-path result carries data");

   // count stays below the modulus
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[41:12] < PATH_MOD[COUNT_W-1:0])
      else $error("path count not reduced");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind grid_max_path_count gmpc_checker u_gmpc_checker (.*);

[sim/grid_max_path_count_tb.sv]
// grid_max_path_count_tb: streams whole boards through the block and checks each board result
// against a cycle-free model of the best-path recurrence kept in a small scoreboard class
// depends on gmpc_pkg and grid_max_path_count
`timescale 1ns / 1ps

module grid_max_path_count_tb;
   import gmpc_pkg::*;

   localparam int MAX_SIDE     = 128;
   localparam int RANDOM_CELLS = 480;
   localparam int MIN_BOARDS   = 15;
   localparam int SETTLE       = 4;
   localparam int DRAIN        = 10;
   localparam int LONG_HOLD    = 300;
   localparam int IDLE_LIMIT   = 3000;

   // one board result as the block reports it
   typedef struct {
      logic [BEST_W-1:0]  score;
      logic [COUNT_W-1:0] count;
      logic               reach;
   } board_result_type;

   // running best score and best-path count per cell, one board result per top-left cell
   class board_tally_type;
      int unsigned      side;
      pair_type         row_pair [MAX_SIDE];
      pair_type         right_pair;
      pair_type         diag_pair;
      int unsigned      col;
      int unsigned      row;
      board_result_type awaited [$];
      int unsigned      errors;
      int unsigned      results_seen;

      function new();
         side = 1;
         errors = 0;
         results_seen = 0;
         foreach (row_pair[i]) row_pair[i] = NO_PAIR;
         restart();
      endfunction

      function void restart();
         col = side - 1;
         row = side - 1;
         right_pair = NO_PAIR;
         diag_pair = NO_PAIR;
      endfunction

      // board_size write, with out-of-range sides clamped
      function void set_side(logic [BOARD_W-1:0] value);
         if (value == 0) side = 1;
         else if (value > MAX_SIDE) side = MAX_SIDE;
         else side = 32'(value);
         restart();
      endfunction

      // one accepted cell
      function void note_cell(logic [KIND_W-1:0] kind, logic [DIGIT_W-1:0] digit);
         pair_type           below;
         pair_type           fresh;
         logic [SCORE_W-1:0] best;
         logic [SCORE_W-1:0] gain;
         logic [SCORE_W-1:0] raised;
         longint unsigned    total;
         board_result_type   outcome;
         // right edge: nothing to the right or below-right
         if (col == side - 1) begin
            right_pair = NO_PAIR;
            diag_pair = NO_PAIR;
         end
         below = (row == side - 1) ? NO_PAIR : row_pair[col];
         fresh = NO_PAIR;
         if (kind == KIND_START) begin
            fresh.score = '0;
            fresh.count = COUNT_W'(1);
         end else if (kind != KIND_OBSTACLE) begin
            best = NO_PATH;
            if (below.score != NO_PATH) best = below.score;
            if (right_pair.score != NO_PATH && (best == NO_PATH || right_pair.score > best))
               best = right_pair.score;
            if (diag_pair.score != NO_PATH && (best == NO_PATH || diag_pair.score > best))
               best = diag_pair.score;
            if (best != NO_PATH) begin
               // end cells add nothing, digits saturate at nine
               gain = '0;
               if (kind == KIND_DIGIT)
                  gain = SCORE_W'((digit > MAX_DIGIT) ? MAX_DIGIT : digit);
               total = 0;
               if (below.score == best) total += 64'(below.count);
               if (right_pair.score == best) total += 64'(right_pair.count);
               if (diag_pair.score == best) total += 64'(diag_pair.count);
               raised = best + gain;
               fresh.score = {1'b0, raised[BEST_W-1:0]};
               fresh.count = COUNT_W'(total % 64'(PATH_MOD));
            end
         end
         diag_pair = below;
         right_pair = fresh;
         row_pair[col] = fresh;
         // advance, emitting after the top-left cell
         if (col == 0 && row == 0) begin
            outcome.reach = (fresh.score != NO_PATH);
            outcome.score = outcome.reach ? fresh.score[BEST_W-1:0] : '0;
            outcome.count = outcome.reach ? fresh.count : '0;
            awaited.push_back(outcome);
            restart();
         end else if (col == 0) begin
            col = side - 1;
            row--;
         end else begin
            col--;
         end
      endfunction

      // one accepted board result against the oldest expected one
      function void check_board(logic [RSP_TDATA_W-1:0] data, logic [RSP_TUSER_W-1:0] user);
         board_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result, data %h user %h", $time, data, user);
            errors++;
         end else begin
            want = awaited.pop_front();
            results_seen++;
            if (data[BEST_W-1:0] !== want.score) begin
               $display("%0t: best_score expected %0d got %0d", $time, want.score,
                        data[BEST_W-1:0]);
               errors++;
            end
            if (data[BEST_W+COUNT_W-1:BEST_W] !== want.count) begin
               $display("%0t: path_count expected %0d got %0d", $time, want.count,
                        data[BEST_W+COUNT_W-1:BEST_W]);
               errors++;
            end
            if (user[0] !== want.reach) begin
               $display("%0t: reachable expected %0d got %0d", $time, want.reach, user[0]);
               errors++;
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [BOARD_W-1:0]     csr_data = '0;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;

   board_tally_type tally = new();
   int unsigned     cells_sent = 0;
   int unsigned     burst_left = 0;
   bit              stall_request = 1'b0;
   int unsigned     idle_cycles = 0;

   grid_max_path_count #(.MAX_SIDE(MAX_SIDE)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #5 clock = ~clock;

   // handshake monitor: config, cells and results as the block accepts them
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tally.set_side(csr_data);
         if (req_tvalid && req_tready)
            tally.note_cell(req_tuser[KIND_W-1:0], req_tdata[DIGIT_W-1:0]);
         if (rsp_tvalid && rsp_tready) tally.check_board(rsp_tdata, rsp_tuser);
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (csr_valid && csr_ready) || (req_tvalid && req_tready) ||
          (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("grid_max_path_count_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: stall patterns, plus one long hold on request
   initial begin
      int unsigned pattern_left;
      int unsigned pattern_mode;
      int unsigned hold_left;
      pattern_left = 0;
      pattern_mode = 0;
      hold_left = 0;
      forever begin
         if (pattern_left == 0) begin
            pattern_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(20, 200);
         end
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            case (pattern_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 4) == 0);
               default: rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
            pattern_left--;
         end
      end
   end

   // one cell, offered in bursts with random gaps; called and returns at a falling edge
   task automatic send_cell(logic [KIND_W-1:0] kind, logic [DIGIT_W-1:0] digit);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {{(REQ_TDATA_W-DIGIT_W){1'b0}}, digit};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
      cells_sent++;
   endtask

   // stop offering and let every pending board result come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tally.awaited.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_board_size(logic [BOARD_W-1:0] value);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one full board; a tidy board has a start in the lower right quadrant and few obstacles
   task automatic send_board(int side, bit tidy, bit few_digits);
      int                  r;
      int                  c;
      int                  roll;
      int                  sr;
      int                  sc;
      int                  sr2;
      int                  sc2;
      bit                  two_starts;
      bit                  end_corner;
      logic [KIND_W-1:0]   kind;
      logic [DIGIT_W-1:0]  digit;
      sr = $urandom_range(side / 2, side - 1);
      sc = $urandom_range(side / 2, side - 1);
      sr2 = $urandom_range(0, side - 1);
      sc2 = $urandom_range(0, side - 1);
      two_starts = ($urandom_range(0, 4) == 0);
      end_corner = $urandom_range(0, 1);
      for (r = side - 1; r >= 0; r--) begin
         for (c = side - 1; c >= 0; c--) begin
            digit = few_digits ? DIGIT_W'($urandom_range(0, 1))
                               : DIGIT_W'($urandom_range(0, 15));
            roll = $urandom_range(0, 99);
            if (!tidy) kind = KIND_W'($urandom_range(0, 3));
            else if ((r == sr && c == sc) || (two_starts && r == sr2 && c == sc2))
               kind = KIND_START;
            else if (r == 0 && c == 0 && end_corner) kind = KIND_END;
            else if (roll < 12) kind = KIND_OBSTACLE;
            else if (roll < 15) kind = KIND_END;
            else kind = KIND_DIGIT;
            send_cell(kind, digit);
         end
      end
   endtask

   initial begin
      int unsigned cell_mark;
      int unsigned board_mark;
      int unsigned roll;
      int          side;
      int          i;
      logic [BOARD_W-1:0] value;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-cell boards, side zero acting as one
      write_board_size(8'd0);
      send_cell(KIND_START, 4'd0);
      send_cell(KIND_DIGIT, 4'd15);
      send_cell(KIND_OBSTACLE, 4'd3);
      send_cell(KIND_END, 4'd7);

      // two by two: saturated digit, three tied paths, start off the corner
      wait_idle();
      write_board_size(8'd2);
      send_cell(KIND_START, 4'd0);
      send_cell(KIND_DIGIT, 4'd15);
      send_cell(KIND_DIGIT, 4'd9);
      send_cell(KIND_END, 4'd0);
      send_cell(KIND_START, 4'd0);
      send_cell(KIND_DIGIT, 4'd0);
      send_cell(KIND_DIGIT, 4'd0);
      send_cell(KIND_DIGIT, 4'd0);
      send_cell(KIND_DIGIT, 4'd5);
      send_cell(KIND_START, 4'd0);
      send_cell(KIND_OBSTACLE, 4'd0);
      send_cell(KIND_DIGIT, 4'd7);

      // board abandoned partway, then a fresh board with two starts
      wait_idle();
      write_board_size(8'd3);
      send_cell(KIND_START, 4'd0);
      send_cell(KIND_DIGIT, 4'd4);
      send_cell(KIND_DIGIT, 4'd2);
      send_cell(KIND_DIGIT, 4'd1);
      wait_idle();
      write_board_size(8'd2);
      send_cell(KIND_OBSTACLE, 4'd8);
      send_cell(KIND_START, 4'd0);
      send_cell(KIND_START, 4'd0);
      send_cell(KIND_DIGIT, 4'd3);

      // largest side: a partial board into the second row, then another from an oversize value
      wait_idle();
      write_board_size(8'd128);
      for (i = 0; i < 200; i++)
         send_cell(i == 0 ? KIND_START : KIND_DIGIT, DIGIT_W'($urandom_range(0, 15)));
      wait_idle();
      write_board_size(8'd255);
      for (i = 0; i < 140; i++)
         send_cell(i == 0 ? KIND_START : KIND_DIGIT, DIGIT_W'($urandom_range(9, 15)));

      // random boards, mostly small; the receiver holds off at the start
      wait_idle();
      @(posedge clock);
      stall_request = 1'b1;
      @(negedge clock);
      cell_mark = cells_sent;
      board_mark = tally.results_seen;
      while (cells_sent - cell_mark < RANDOM_CELLS ||
             tally.results_seen - board_mark < MIN_BOARDS) begin
         roll = $urandom_range(0, 19);
         if (roll < 16) side = $urandom_range(1, 4);
         else if (roll < 19) side = $urandom_range(5, 8);
         else side = $urandom_range(9, 14);
         value = (side == 1 && $urandom_range(0, 1)) ? 8'd0 : BOARD_W'(side);
         wait_idle();
         write_board_size(value);
         repeat ($urandom_range(1, 3))
            send_board(side, $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
      end

      // drain
      req_tvalid <= 1'b0;
      while (tally.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (tally.errors == 0 && tally.awaited.size() == 0) begin
         $display("grid_max_path_count_tb passed");
      end else begin
         $display("grid_max_path_count_tb failed");
      end
      $finish;
   end

endmodule
